### hdl/bfa_pkg.sv
// Shared types, codes and defaults of the bitmap frame allocator.
`timescale 1ns / 1ps
`default_nettype none
package bfa_pkg;

   localparam int DEF_NUM_FRAMES  = 65536;
   localparam int DEF_WORD_BITS   = 32;
   localparam int DEF_MAX_GUARDED = 64;
   localparam int DEF_MAX_RUN     = 1024;

   localparam int CSR_W = 17;
   localparam logic [CSR_W-1:0] CSR_RESET = 17'h10000;
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   localparam logic [3:0] ACT_ALLOC    = 4'd0;
   localparam logic [3:0] ACT_RUN      = 4'd1;
   localparam logic [3:0] ACT_FREE     = 4'd2;
   localparam logic [3:0] ACT_INC      = 4'd3;
   localparam logic [3:0] ACT_DEC      = 4'd4;
   localparam logic [3:0] ACT_QUERY    = 4'd5;
   localparam logic [3:0] ACT_PROTECT  = 4'd6;
   localparam logic [3:0] ACT_UNPROT   = 4'd7;
   localparam logic [3:0] ACT_PQUERY   = 4'd8;
   localparam logic [3:0] ACT_MARK     = 4'd9;

   localparam logic [3:0] ST_OK        = 4'd0;
   localparam logic [3:0] ST_INVALID   = 4'd1;
   localparam logic [3:0] ST_NONE_FREE = 4'd2;
   localparam logic [3:0] ST_NOT_USED  = 4'd3;
   localparam logic [3:0] ST_PROTECTED = 4'd4;
   localparam logic [3:0] ST_FULL      = 4'd5;
   localparam logic [3:0] ST_NOT_FOUND = 4'd6;
   localparam logic [3:0] ST_OVERFLOW  = 4'd7;
   localparam logic [3:0] ST_ZERO      = 4'd8;

   typedef struct packed {
      logic [3:0]  action;
      logic [15:0] frame;
      logic [10:0] run_len;
      logic        mark;
      logic        f_nz;
      logic        f_in;
      logic        len_ok;
      logic        len_one;
   } bfa_req_type;

   typedef struct packed {
      logic        valid;
      bfa_req_type item;
   } bfa_head_type;

   typedef struct packed {
      logic pop;
      logic clearing;
   } bfa_back_stat_type;

endpackage
`default_nettype wire

### hdl/bitmap_frame_allocator_unit.sv
// Top level of the bitmap frame allocator: config register, front end, back end.
`timescale 1ns / 1ps
`default_nettype none
// Frame allocator over a used-bit bitmap with per-frame reference counts and a
// protected-frame table. After reset the block runs a clearing pass over every
// frame (busy high) before it takes the first request. Requests enter a two-deep
// queue; each gives one result as a single-cycle rsp_strobe that cannot be held
// off. Count, mark and query requests pass through S_DIV1, S_DIV2, S_RD and
// S_EXEC; every lookup in the protected table reads and compares one entry after
// another (S_GISSUE, S_GCMP) until a hit or the end of the table.
// A single allocation reads bitmap words from the cursor on; a run allocation
// of more than one frame scans words from frame 0, one bit per cycle in a partly
// used word, then reads and writes the bitmap word for each frame of the run.
module bitmap_frame_allocator_unit import bfa_pkg::*; #(
   parameter int NUM_FRAMES  = DEF_NUM_FRAMES,
   parameter int WORD_BITS   = DEF_WORD_BITS,
   parameter int MAX_GUARDED = DEF_MAX_GUARDED,
   parameter int MAX_RUN     = DEF_MAX_RUN
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [3:0]        req_action,
   input  logic [15:0]       req_frame_index,
   input  logic [10:0]       req_run_length,
   input  logic              req_mark_used,
   output logic              rsp_strobe,
   output logic [3:0]        rsp_status,
   output logic [15:0]       rsp_result_frame,
   output logic [15:0]       rsp_ref_count,
   output logic              rsp_is_protected,
   output logic [16:0]       rsp_free_total,
   input  logic              csr_write_enable,
   input  logic [16:0]       csr_write_data
);

   localparam int TW = $clog2(NUM_FRAMES) + 1;
   localparam int CW = (TW > CSR_W) ? TW : CSR_W;

   logic [CSR_W-1:0]  fiu_ff;
   logic [TW-1:0]     tot;
   bfa_head_type      head;
   bfa_back_stat_type back_stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         fiu_ff <= CSR_RESET;
      end else if (csr_write_enable) begin
         fiu_ff <= csr_write_data;
      end
   end

   assign tot = (CW'(fiu_ff) > CW'(NUM_FRAMES)) ? TW'(NUM_FRAMES) : TW'(fiu_ff);

   bfa_front #(
      .NUM_FRAMES (NUM_FRAMES),
      .MAX_RUN    (MAX_RUN)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_frame_index (req_frame_index),
      .req_run_length  (req_run_length),
      .req_mark_used   (req_mark_used),
      .tot             (tot),
      .back_stat       (back_stat),
      .head            (head)
   );

   bfa_back #(
      .NUM_FRAMES  (NUM_FRAMES),
      .WORD_BITS   (WORD_BITS),
      .MAX_GUARDED (MAX_GUARDED),
      .MAX_RUN     (MAX_RUN)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .tot              (tot),
      .head             (head),
      .back_stat        (back_stat),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_result_frame (rsp_result_frame),
      .rsp_ref_count    (rsp_ref_count),
      .rsp_is_protected (rsp_is_protected),
      .rsp_free_total   (rsp_free_total)
   );

   a_fail_no_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status != ST_OK |-> rsp_result_frame == 16'd0)
      else $error("failed request returned a frame");

   a_prot_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_is_protected |-> rsp_status == ST_OK)
      else $error("protection flag on failed request");

   a_alloc_count: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_result_frame != 16'd0 |-> rsp_ref_count == 16'd1)
      else $error("allocated frame without count of one");

   a_clear_busy: assert property (@(posedge clock)
      !reset && $past(reset) |-> busy)
      else $error("ready during clearing pass");

endmodule
`default_nettype wire

### hdl/bfa_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
`timescale 1ns / 1ps
`default_nettype none
module bfa_front import bfa_pkg::*; #(
   parameter int NUM_FRAMES = DEF_NUM_FRAMES,
   parameter int MAX_RUN    = DEF_MAX_RUN
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [3:0]                    req_action,
   input  logic [15:0]                   req_frame_index,
   input  logic [10:0]                   req_run_length,
   input  logic                          req_mark_used,
   input  logic [$clog2(NUM_FRAMES):0]   tot,
   input  bfa_back_stat_type             back_stat,
   output bfa_head_type                  head
);

   localparam int TW = $clog2(NUM_FRAMES) + 1;
   localparam int CW = (TW > 17) ? TW : 17;

   bfa_req_type q_ff [2];
   logic        wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]  n_ff, n_in;
   logic        push;
   bfa_req_type cls;

   assign busy = (n_ff == 2'd2) || back_stat.clearing;
   assign push = start && !busy;

   always_comb begin
      cls.action  = req_action;
      cls.frame   = req_frame_index;
      cls.run_len = req_run_length;
      cls.mark    = req_mark_used;
      cls.f_nz    = req_frame_index != 16'd0;
      cls.f_in    = CW'(req_frame_index) < CW'(tot);
      cls.len_ok  = (req_run_length != 11'd0) && (32'(req_run_length) <= MAX_RUN);
      cls.len_one = req_run_length == 11'd1;
   end

   always_comb begin
      wp_in = wp_ff;
      rp_in = rp_ff;
      n_in  = n_ff;
      if (push) begin
         wp_in = !wp_ff;
      end
      if (back_stat.pop) begin
         rp_in = !rp_ff;
      end
      if (push && !back_stat.pop) begin
         n_in = n_ff + 2'd1;
      end else if (!push && back_stat.pop) begin
         n_in = n_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         n_ff  <= 2'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         n_ff  <= n_in;
      end
      if (push) begin
         q_ff[wp_ff] <= cls;
      end
   end

   assign head.valid = n_ff != 2'd0;
   assign head.item  = q_ff[rp_ff];

endmodule
`default_nettype wire

### hdl/bfa_back.sv
// Back end: sequencer over the bitmap, count and protection memories.
`timescale 1ns / 1ps
`default_nettype none
module bfa_back import bfa_pkg::*; #(
   parameter int NUM_FRAMES  = DEF_NUM_FRAMES,
   parameter int WORD_BITS   = DEF_WORD_BITS,
   parameter int MAX_GUARDED = DEF_MAX_GUARDED,
   parameter int MAX_RUN     = DEF_MAX_RUN
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [$clog2(NUM_FRAMES):0]   tot,
   input  bfa_head_type                  head,
   output bfa_back_stat_type             back_stat,
   output logic                          rsp_strobe,
   output logic [3:0]                    rsp_status,
   output logic [15:0]                   rsp_result_frame,
   output logic [15:0]                   rsp_ref_count,
   output logic                          rsp_is_protected,
   output logic [16:0]                   rsp_free_total
);

   localparam int FW   = $clog2(NUM_FRAMES);
   localparam int TW   = FW + 1;
   localparam int WC   = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
   localparam int WAW  = (WC > 1) ? $clog2(WC) : 1;
   localparam int BW   = $clog2(WORD_BITS);
   localparam int GAW  = (MAX_GUARDED > 1) ? $clog2(MAX_GUARDED) : 1;
   localparam int GEW  = $clog2(MAX_GUARDED + 1);
   localparam int GTW  = (FW > 16) ? FW : 16;
   localparam int RW   = $clog2(MAX_RUN + WORD_BITS + 1);
   localparam int SH   = FW + 8;
   localparam int MULT = (2 ** SH) / WORD_BITS;
   localparam int PW   = FW + SH;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_DIV1, S_DIV2, S_RD, S_EXEC, S_FREE2, S_GISSUE, S_GCMP,
      S_PRE_B, S_PINC, S_U1, S_U2, S_AS_MUL, S_AS_INIT, S_AS_RD, S_AS_CHK,
      S_AS_TAKE, S_AR_RD, S_AR_CHK, S_AR_BIT, S_TK_RD, S_TK_WR
   } state_type;

   // memories
   logic [WORD_BITS-1:0] bm_mem [WC];
   logic [15:0]          cnt_mem [NUM_FRAMES];
   logic [15:0]          gf_mem [MAX_GUARDED];
   logic [15:0]          gc_mem [MAX_GUARDED];
   logic [WORD_BITS-1:0] bm_rd_ff;
   logic [15:0]          cnt_rd_ff, gf_rd_ff, gc_rd_ff;

   logic                 bm_we, bm_re;
   logic [WAW-1:0]       bm_waddr, bm_raddr;
   logic [WORD_BITS-1:0] bm_wdata;
   logic                 cnt_we, cnt_re;
   logic [FW-1:0]        cnt_waddr, cnt_raddr;
   logic [15:0]          cnt_wdata;
   logic                 g_we, g_re;
   logic [GAW-1:0]       g_waddr, g_raddr;
   logic [15:0]          g_wf, g_wc;

   state_type            state_ff, state_in, gret_ff, gret_in;
   logic [3:0]           act_ff, act_in;
   logic [15:0]          frame_ff, frame_in;
   logic [FW-1:0]        fidx_ff, fidx_in;
   logic                 mark_ff, mark_in, f_in_ff, f_in_in;
   logic [10:0]          len_ff, len_in;
   logic [PW-1:0]        prod_ff, prod_in;
   logic [WAW-1:0]       wq_ff, wq_in;
   logic [BW-1:0]        wr_ff, wr_in;
   logic [GEW-1:0]       gi_ff, gi_in, entries_ff, entries_in;
   logic                 ghit_ff, ghit_in;
   logic [GAW-1:0]       gidx_ff, gidx_in;
   logic [GTW-1:0]       gtarget_ff, gtarget_in;
   logic [WAW-1:0]       sw_ff, sw_in;
   logic [TW-1:0]        free_ff, free_in;
   logic [WAW-1:0]       w_ff, w_in, startw_ff, startw_in;
   logic [TW-1:0]        base_ff, base_in, swbase_ff, swbase_in;
   logic [BW-1:0]        fbit_ff, fbit_in;
   logic [FW-1:0]        ffrm_ff, ffrm_in;
   logic [RW-1:0]        run_ff, run_in, k_ff, k_in;
   logic [WORD_BITS-1:0] fmask_ff, fmask_in;
   logic [BW-1:0]        bi_ff, bi_in, rsb_ff, rsb_in, tb_ff, tb_in;
   logic [FW-1:0]        rstart_ff, rstart_in, tf_ff, tf_in;
   logic [WAW-1:0]       rsw_ff, rsw_in, tw_ff, tw_in;
   logic [15:0]          hold_ff, hold_in;
   logic [FW-1:0]        clr_ff, clr_in;

   logic                 rsp_strobe_ff, rsp_strobe_in, rsp_prot_ff, rsp_prot_in;
   logic [3:0]           rsp_status_ff, rsp_status_in;
   logic [15:0]          rsp_frame_ff, rsp_frame_in, rsp_count_ff, rsp_count_in;

   always_ff @(posedge clock) begin
      if (bm_we) begin
         bm_mem[bm_waddr] <= bm_wdata;
      end
      if (bm_re) begin
         bm_rd_ff <= bm_mem[bm_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_waddr] <= cnt_wdata;
      end
      if (cnt_re) begin
         cnt_rd_ff <= cnt_mem[cnt_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (g_we) begin
         gf_mem[g_waddr] <= g_wf;
         gc_mem[g_waddr] <= g_wc;
      end
      if (g_re) begin
         gf_rd_ff <= gf_mem[g_raddr];
         gc_rd_ff <= gc_mem[g_raddr];
      end
   end

   always_comb begin
      logic                 r_go, r_prot;
      logic [3:0]           r_st;
      logic [15:0]          r_frame, r_cnt, c, c2;
      logic [TW-1:0]        free_dec, free_inc, nb, rfull, qw;
      logic [FW-1:0]        q0;
      logic [WORD_BITS-1:0] freev, wbit;
      logic                 hit, bitv;
      logic [BW-1:0]        hb;
      logic [TW-1:0]        cand;
      logic [WAW-1:0]       nw, st_w;
      logic [FW-1:0]        st_f;
      logic [BW-1:0]        st_b;
      logic                 g_start;
      logic [GTW-1:0]       g_tgt;
      state_type            g_ret;

      state_in = state_ff;     gret_in = gret_ff;     act_in = act_ff;
      frame_in = frame_ff;     fidx_in = fidx_ff;     mark_in = mark_ff;
      f_in_in = f_in_ff;       len_in = len_ff;       prod_in = prod_ff;
      wq_in = wq_ff;           wr_in = wr_ff;         gi_in = gi_ff;
      entries_in = entries_ff; ghit_in = ghit_ff;     gidx_in = gidx_ff;
      gtarget_in = gtarget_ff; sw_in = sw_ff;         free_in = free_ff;
      w_in = w_ff;             startw_in = startw_ff; base_in = base_ff;
      swbase_in = swbase_ff;   fbit_in = fbit_ff;     ffrm_in = ffrm_ff;
      run_in = run_ff;         k_in = k_ff;           fmask_in = fmask_ff;
      bi_in = bi_ff;           rsb_in = rsb_ff;       tb_in = tb_ff;
      rstart_in = rstart_ff;   tf_in = tf_ff;         rsw_in = rsw_ff;
      tw_in = tw_ff;           hold_in = hold_ff;     clr_in = clr_ff;
      rsp_strobe_in = 1'b0;    rsp_status_in = rsp_status_ff;
      rsp_frame_in = rsp_frame_ff; rsp_count_in = rsp_count_ff;
      rsp_prot_in = rsp_prot_ff;

      bm_we = 1'b0; bm_re = 1'b0; bm_waddr = '0; bm_raddr = '0; bm_wdata = '0;
      cnt_we = 1'b0; cnt_re = 1'b0; cnt_waddr = '0; cnt_raddr = '0; cnt_wdata = '0;
      g_we = 1'b0; g_re = 1'b0; g_waddr = '0; g_raddr = '0; g_wf = '0; g_wc = '0;

      r_go = 1'b0; r_prot = 1'b0; r_st = ST_OK; r_frame = '0; r_cnt = '0;
      g_start = 1'b0; g_tgt = '0; g_ret = S_IDLE;
      free_dec = (free_ff != '0) ? free_ff - TW'(1) : free_ff;
      free_inc = free_ff + TW'(1);
      c = '0; c2 = '0; nb = '0; rfull = '0; qw = '0; q0 = '0;
      hit = 1'b0; hb = '0; cand = '0; nw = '0;
      st_w = '0; st_f = '0; st_b = '0;
      wbit = WORD_BITS'(1) << wr_ff;
      bitv = bm_rd_ff[wr_ff];
      for (int b = 0; b < WORD_BITS; b++) begin
         freev[b] = !bm_rd_ff[b] && ((base_ff + TW'(b)) < tot);
      end
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (freev[b]) begin
            hit = 1'b1;
            hb  = BW'(b);
         end
      end

      case (state_ff)
         S_CLEAR: begin
            cnt_we = 1'b1;
            cnt_waddr = clr_ff;
            cnt_wdata = '0;
            if (32'(clr_ff) < WC) begin
               bm_we = 1'b1;
               bm_waddr = WAW'(clr_ff);
               bm_wdata = '1;
            end
            if (32'(clr_ff) == NUM_FRAMES - 1) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + FW'(1);
            end
         end
         S_IDLE: begin
            if (head.valid) begin
               act_in   = head.item.action;
               frame_in = head.item.frame;
               fidx_in  = FW'(head.item.frame);
               mark_in  = head.item.mark;
               f_in_in  = head.item.f_in;
               len_in   = head.item.run_len;
               case (head.item.action)
                  ACT_ALLOC: state_in = S_AS_MUL;
                  ACT_RUN: begin
                     if (!head.item.len_ok) begin
                        r_go = 1'b1; r_st = ST_INVALID;
                     end else if (head.item.len_one) begin
                        state_in = S_AS_MUL;
                     end else begin
                        w_in = '0; base_in = '0; run_in = '0;
                        state_in = S_AR_RD;
                     end
                  end
                  ACT_FREE, ACT_INC, ACT_DEC, ACT_QUERY, ACT_MARK: begin
                     if (!(head.item.f_nz && head.item.f_in)) begin
                        r_go = 1'b1; r_st = ST_INVALID;
                     end else begin
                        state_in = S_DIV1;
                     end
                  end
                  ACT_PROTECT, ACT_UNPROT, ACT_PQUERY: begin
                     if (!head.item.f_nz) begin
                        r_go = 1'b1; r_st = ST_INVALID;
                     end else begin
                        g_start = 1'b1; g_tgt = GTW'(head.item.frame); g_ret = S_PRE_B;
                     end
                  end
                  default: begin
                     r_go = 1'b1; r_st = ST_INVALID;
                  end
               endcase
            end
         end
         S_GISSUE: begin
            if (gi_ff >= entries_ff) begin
               ghit_in = 1'b0;
               state_in = gret_ff;
            end else begin
               g_re = 1'b1;
               g_raddr = gi_ff[GAW-1:0];
               state_in = S_GCMP;
            end
         end
         S_GCMP: begin
            if (GTW'(gf_rd_ff) == gtarget_ff) begin
               ghit_in = 1'b1;
               gidx_in = gi_ff[GAW-1:0];
               state_in = gret_ff;
            end else begin
               gi_in = gi_ff + GEW'(1);
               state_in = S_GISSUE;
            end
         end
         S_PRE_B: state_in = f_in_ff ? S_DIV1 : S_EXEC;
         // word and bit of the frame: reciprocal multiply, then one correction
         S_DIV1: begin
            prod_in = PW'(fidx_ff) * PW'(MULT);
            state_in = S_DIV2;
         end
         S_DIV2: begin
            q0 = FW'(prod_ff >> SH);
            qw = TW'(q0) * TW'(WORD_BITS);
            rfull = TW'(fidx_ff) - qw;
            if (rfull >= TW'(WORD_BITS)) begin
               wq_in = WAW'(q0 + FW'(1));
               wr_in = BW'(rfull - TW'(WORD_BITS));
            end else begin
               wq_in = WAW'(q0);
               wr_in = BW'(rfull);
            end
            state_in = S_RD;
         end
         S_RD: begin
            bm_re = 1'b1; bm_raddr = wq_ff;
            cnt_re = 1'b1; cnt_raddr = fidx_ff;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            c = f_in_ff ? cnt_rd_ff : 16'd0;
            r_cnt = c;
            case (act_ff)
               ACT_INC: begin
                  r_go = 1'b1;
                  if (c == COUNT_MAX) begin
                     r_st = ST_OVERFLOW;
                  end else begin
                     cnt_we = 1'b1; cnt_waddr = fidx_ff; cnt_wdata = c + 16'd1;
                     r_cnt = c + 16'd1;
                  end
               end
               ACT_DEC: begin
                  r_go = 1'b1;
                  if (c == 16'd0) begin
                     r_st = ST_ZERO;
                  end else begin
                     cnt_we = 1'b1; cnt_waddr = fidx_ff; cnt_wdata = c - 16'd1;
                     r_cnt = c - 16'd1;
                  end
               end
               ACT_QUERY: r_go = 1'b1;
               ACT_MARK: begin
                  r_go = 1'b1;
                  if (!mark_ff && bitv) begin
                     bm_we = 1'b1; bm_waddr = wq_ff; bm_wdata = bm_rd_ff & ~wbit;
                     cnt_we = 1'b1; cnt_waddr = fidx_ff; cnt_wdata = 16'd0;
                     free_in = free_inc;
                     r_cnt = 16'd0;
                  end else if (mark_ff && !bitv) begin
                     bm_we = 1'b1; bm_waddr = wq_ff; bm_wdata = bm_rd_ff | wbit;
                     cnt_we = 1'b1; cnt_waddr = fidx_ff; cnt_wdata = 16'd1;
                     free_in = free_dec;
                     r_cnt = 16'd1;
                  end
               end
               ACT_FREE: begin
                  if (!bitv) begin
                     r_go = 1'b1; r_st = ST_NOT_USED;
                  end else begin
                     g_start = 1'b1; g_tgt = GTW'(frame_ff); g_ret = S_FREE2;
                  end
               end
               ACT_PQUERY: begin
                  r_go = 1'b1; r_prot = ghit_ff;
               end
               ACT_PROTECT: begin
                  c2 = c;
                  if (f_in_ff && !bitv) begin
                     bm_we = 1'b1; bm_waddr = wq_ff; bm_wdata = bm_rd_ff | wbit;
                     cnt_we = 1'b1; cnt_waddr = fidx_ff; cnt_wdata = 16'd1;
                     free_in = free_dec;
                     c2 = 16'd1;
                  end
                  hold_in = c2;
                  r_cnt = c2;
                  if (ghit_ff) begin
                     g_re = 1'b1; g_raddr = gidx_ff;
                     state_in = S_PINC;
                  end else if (32'(entries_ff) < MAX_GUARDED) begin
                     g_we = 1'b1; g_waddr = entries_ff[GAW-1:0];
                     g_wf = frame_ff; g_wc = 16'd1;
                     entries_in = entries_ff + GEW'(1);
                     r_go = 1'b1;
                  end else begin
                     r_go = 1'b1; r_st = ST_FULL;
                  end
               end
               ACT_UNPROT: begin
                  hold_in = c;
                  if (!ghit_ff) begin
                     r_go = 1'b1; r_st = ST_NOT_FOUND;
                  end else begin
                     g_re = 1'b1; g_raddr = gidx_ff;
                     state_in = S_U1;
                  end
               end
               default: begin
                  r_go = 1'b1; r_st = ST_INVALID; r_cnt = '0;
               end
            endcase
         end
         S_FREE2: begin
            c = cnt_rd_ff;
            r_go = 1'b1;
            r_cnt = c;
            if (ghit_ff) begin
               r_st = ST_PROTECTED;
            end else begin
               c2 = (c != 16'd0) ? c - 16'd1 : 16'd0;
               cnt_we = 1'b1; cnt_waddr = fidx_ff; cnt_wdata = c2;
               r_cnt = c2;
               if (c2 == 16'd0) begin
                  bm_we = 1'b1; bm_waddr = wq_ff; bm_wdata = bm_rd_ff & ~wbit;
                  free_in = free_inc;
                  if (wq_ff < sw_ff) begin
                     sw_in = wq_ff;
                  end
               end
            end
         end
         S_PINC: begin
            g_we = 1'b1; g_waddr = gidx_ff; g_wf = frame_ff;
            g_wc = (gc_rd_ff == COUNT_MAX) ? gc_rd_ff : gc_rd_ff + 16'd1;
            r_go = 1'b1; r_cnt = hold_ff;
         end
         S_U1: begin
            c2 = (gc_rd_ff != 16'd0) ? gc_rd_ff - 16'd1 : 16'd0;
            if (c2 == 16'd0) begin
               // move the last entry into the freed slot
               entries_in = entries_ff - GEW'(1);
               g_re = 1'b1; g_raddr = GAW'(entries_ff - GEW'(1));
               state_in = S_U2;
            end else begin
               g_we = 1'b1; g_waddr = gidx_ff; g_wf = frame_ff; g_wc = c2;
               r_go = 1'b1; r_cnt = hold_ff;
            end
         end
         S_U2: begin
            g_we = 1'b1; g_waddr = gidx_ff; g_wf = gf_rd_ff; g_wc = gc_rd_ff;
            r_go = 1'b1; r_cnt = hold_ff;
         end
         S_AS_MUL: begin
            swbase_in = TW'(sw_ff) * TW'(WORD_BITS);
            state_in = S_AS_INIT;
         end
         S_AS_INIT: begin
            if (tot == '0) begin
               r_go = 1'b1; r_st = ST_NONE_FREE;
            end else begin
               if (swbase_ff >= tot) begin
                  w_in = '0; base_in = '0; startw_in = '0;
               end else begin
                  w_in = sw_ff; base_in = swbase_ff; startw_in = sw_ff;
               end
               state_in = S_AS_RD;
            end
         end
         S_AS_RD: begin
            bm_re = 1'b1; bm_raddr = w_ff;
            state_in = S_AS_CHK;
         end
         S_AS_CHK: begin
            if (hit) begin
               cand = base_ff + TW'(hb);
               fbit_in = hb;
               ffrm_in = FW'(cand);
               sw_in = w_ff;
               g_start = 1'b1; g_tgt = GTW'(cand); g_ret = S_AS_TAKE;
            end else begin
               nb = base_ff + TW'(WORD_BITS);
               if (nb >= tot) begin
                  nw = '0; nb = '0;
               end else begin
                  nw = w_ff + WAW'(1);
               end
               if (nw == startw_ff) begin
                  r_go = 1'b1; r_st = ST_NONE_FREE;
               end else begin
                  w_in = nw; base_in = nb;
                  state_in = S_AS_RD;
               end
            end
         end
         S_AS_TAKE: begin
            r_go = 1'b1;
            if (ghit_ff) begin
               r_st = ST_PROTECTED;
            end else begin
               bm_we = 1'b1; bm_waddr = w_ff;
               bm_wdata = bm_rd_ff | (WORD_BITS'(1) << fbit_ff);
               cnt_we = 1'b1; cnt_waddr = ffrm_ff; cnt_wdata = 16'd1;
               free_in = free_dec;
               r_frame = 16'(ffrm_ff); r_cnt = 16'd1;
            end
         end
         S_AR_RD: begin
            bm_re = 1'b1; bm_raddr = w_ff;
            state_in = S_AR_CHK;
         end
         S_AR_CHK: begin
            nb = base_ff + TW'(WORD_BITS);
            if (&freev) begin
               st_w = (run_ff == '0) ? w_ff : rsw_ff;
               st_b = (run_ff == '0) ? '0 : rsb_ff;
               st_f = (run_ff == '0) ? FW'(base_ff) : rstart_ff;
               rstart_in = st_f; rsw_in = st_w; rsb_in = st_b;
               if (run_ff + RW'(WORD_BITS) >= RW'(len_ff)) begin
                  tw_in = st_w; tb_in = st_b; tf_in = st_f; k_in = '0;
                  state_in = S_TK_RD;
               end else begin
                  run_in = run_ff + RW'(WORD_BITS);
                  if (nb >= tot) begin
                     r_go = 1'b1; r_st = ST_NONE_FREE;
                  end else begin
                     w_in = w_ff + WAW'(1); base_in = nb;
                     state_in = S_AR_RD;
                  end
               end
            end else if (freev == '0) begin
               run_in = '0;
               if (nb >= tot) begin
                  r_go = 1'b1; r_st = ST_NONE_FREE;
               end else begin
                  w_in = w_ff + WAW'(1); base_in = nb;
                  state_in = S_AR_RD;
               end
            end else begin
               fmask_in = freev; bi_in = '0;
               state_in = S_AR_BIT;
            end
         end
         // mixed word: one bit per cycle
         S_AR_BIT: begin
            nb = base_ff + TW'(WORD_BITS);
            if (fmask_ff[bi_ff]) begin
               st_w = (run_ff == '0) ? w_ff : rsw_ff;
               st_b = (run_ff == '0) ? bi_ff : rsb_ff;
               st_f = (run_ff == '0) ? FW'(base_ff + TW'(bi_ff)) : rstart_ff;
               rstart_in = st_f; rsw_in = st_w; rsb_in = st_b;
               run_in = run_ff + RW'(1);
            end else begin
               run_in = '0;
            end
            if (fmask_ff[bi_ff] && (run_ff + RW'(1) >= RW'(len_ff))) begin
               tw_in = st_w; tb_in = st_b; tf_in = st_f; k_in = '0;
               state_in = S_TK_RD;
            end else if (bi_ff == BW'(WORD_BITS - 1)) begin
               if (nb >= tot) begin
                  r_go = 1'b1; r_st = ST_NONE_FREE;
               end else begin
                  w_in = w_ff + WAW'(1); base_in = nb;
                  state_in = S_AR_RD;
               end
            end else begin
               bi_in = bi_ff + BW'(1);
            end
         end
         S_TK_RD: begin
            bm_re = 1'b1; bm_raddr = tw_ff;
            state_in = S_TK_WR;
         end
         S_TK_WR: begin
            bm_we = 1'b1; bm_waddr = tw_ff;
            bm_wdata = bm_rd_ff | (WORD_BITS'(1) << tb_ff);
            cnt_we = 1'b1; cnt_waddr = tf_ff; cnt_wdata = 16'd1;
            free_in = free_dec;
            k_in = k_ff + RW'(1);
            if (k_ff + RW'(1) == RW'(len_ff)) begin
               r_go = 1'b1; r_frame = 16'(rstart_ff); r_cnt = 16'd1;
            end else begin
               tf_in = tf_ff + FW'(1);
               if (tb_ff == BW'(WORD_BITS - 1)) begin
                  tb_in = '0; tw_in = tw_ff + WAW'(1);
               end else begin
                  tb_in = tb_ff + BW'(1);
               end
               state_in = S_TK_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (g_start) begin
         gi_in = '0; gtarget_in = g_tgt; gret_in = g_ret;
         state_in = S_GISSUE;
      end
      if (r_go) begin
         rsp_strobe_in = 1'b1;
         rsp_status_in = r_st;
         rsp_frame_in  = r_frame;
         rsp_count_in  = r_cnt;
         rsp_prot_in   = r_prot;
         state_in      = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         entries_ff    <= '0;
         sw_ff         <= '0;
         free_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         entries_ff    <= entries_in;
         sw_ff         <= sw_in;
         free_ff       <= free_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      gret_ff <= gret_in;     act_ff <= act_in;       frame_ff <= frame_in;
      fidx_ff <= fidx_in;     mark_ff <= mark_in;     f_in_ff <= f_in_in;
      len_ff <= len_in;       prod_ff <= prod_in;     wq_ff <= wq_in;
      wr_ff <= wr_in;         gi_ff <= gi_in;         ghit_ff <= ghit_in;
      gidx_ff <= gidx_in;     gtarget_ff <= gtarget_in;
      w_ff <= w_in;           startw_ff <= startw_in; base_ff <= base_in;
      swbase_ff <= swbase_in; fbit_ff <= fbit_in;     ffrm_ff <= ffrm_in;
      run_ff <= run_in;       k_ff <= k_in;           fmask_ff <= fmask_in;
      bi_ff <= bi_in;         rsb_ff <= rsb_in;       tb_ff <= tb_in;
      rstart_ff <= rstart_in; tf_ff <= tf_in;         rsw_ff <= rsw_in;
      tw_ff <= tw_in;         hold_ff <= hold_in;
      rsp_status_ff <= rsp_status_in;
      rsp_frame_ff  <= rsp_frame_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_prot_ff   <= rsp_prot_in;
   end

   assign back_stat.pop      = (state_ff == S_IDLE) && head.valid;
   assign back_stat.clearing = state_ff == S_CLEAR;

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_result_frame = rsp_frame_ff;
   assign rsp_ref_count    = rsp_count_ff;
   assign rsp_is_protected = rsp_prot_ff;
   assign rsp_free_total   = 17'(free_ff);

endmodule
`default_nettype wire
